FILE: src/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants of the mandelbrot potential shader
// sequencer states, register indexes, reset values and fixed-point constants
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

    localparam int MaxIterDefault = 4000;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 28;
    localparam int LevelW    = 28;
    localparam int ColorW    = 8;
    localparam int CoordW    = 32;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] RegGradientMode  = 3'd0;
    localparam logic [CfgIndexW-1:0] RegBoundaryLevel = 3'd1;
    localparam logic [CfgIndexW-1:0] RegNoiseLevel    = 3'd2;
    localparam logic [CfgIndexW-1:0] RegBoundaryColor = 3'd3;
    localparam logic [CfgIndexW-1:0] RegNoiseColor    = 3'd4;
    localparam logic [CfgIndexW-1:0] RegInteriorColor = 3'd5;

    // gradient modes
    localparam logic [1:0] GradLinear = 2'd0;
    localparam logic [1:0] GradFrac   = 2'd1;

    localparam logic [1:0]        ResetGradientMode  = 2'd2;
    localparam logic [LevelW-1:0] ResetBoundaryLevel = 28'd16384000;
    localparam logic [LevelW-1:0] ResetNoiseLevel    = 28'd14417920;
    localparam logic [ColorW-1:0] ResetBoundaryColor = 8'd255;
    localparam logic [ColorW-1:0] ResetNoiseColor    = 8'd180;
    localparam logic [ColorW-1:0] ResetInteriorColor = 8'd127;

    // 1e10 in Q36.28
    localparam logic [63:0] EscLimit = 64'd2684354560000000000;
    // ln2 in Q.24
    localparam logic [63:0] Ln2Q24   = 64'd11629080;
    localparam logic [LevelW-1:0] LevelMax = 28'hFFFFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ZRI,
        ST_UPDATE,
        ST_MUL_SR,
        ST_MUL_SI,
        ST_SUM,
        ST_CHECK,
        ST_NORM,
        ST_LOG,
        ST_MUL_LVL,
        ST_LEVEL,
        ST_SQRT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: src/mandelbrot_potential_shader.sv
// ----------------------------------------------------------------------------
// mandelbrot_potential_shader
// escape-time iteration of z = z*z + c with a potential-level grey shade
// ----------------------------------------------------------------------------
// iteration: three 64x64 products on one shared 32x32 multiplier, four
//   partials each, plus update and test
// throughput: one request at a time, busy stays high until the result strobe
// reset: rst_n is asynchronous, returns to idle and reloads register defaults
// the receiver cannot stall: done marks the result for exactly one cycle
`default_nettype none

module mandelbrot_potential_shader #(
    parameter int MAX_ITER = mps_pkg::MaxIterDefault
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [mps_pkg::CoordW-1:0] c_re,
    input  wire logic signed [mps_pkg::CoordW-1:0] c_im,
    output logic                                   done,
    output logic [mps_pkg::ColorW-1:0]             red,
    output logic [mps_pkg::ColorW-1:0]             green,
    output logic [mps_pkg::ColorW-1:0]             blue,
    output logic [mps_pkg::LevelW-1:0]             potential_level,
    input  wire logic                              cfg_we,
    input  wire logic [mps_pkg::CfgIndexW-1:0]     cfg_index,
    input  wire logic [mps_pkg::CfgDataW-1:0]      cfg_data
);

    import mps_pkg::*;

    localparam int NW = $clog2(MAX_ITER + 1);
    localparam int DW = ((NW + 17 > 23) ? NW + 17 : 23) + 1;

    state_t state_reg, state_next;

    logic [1:0]        mode_reg;
    logic [LevelW-1:0] bnd_level_reg, noise_level_reg;
    logic [ColorW-1:0] bnd_color_reg, noise_color_reg, int_color_reg;

    logic [2:0]   step_reg, step_next;
    logic [3:0]   round_reg, round_next;
    logic         phase_reg, phase_next;
    logic         pass_reg, pass_next;
    logic signed [CoordW-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [63:0] zr_reg, zr_next, zi_reg, zi_next;
    logic [127:0] sr_reg, sr_next, si_reg, si_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  prod_reg, prod_next;
    logic [127:0] norm_reg, norm_next;
    logic [6:0]   shcnt_reg, shcnt_next;
    logic [30:0]  m_reg, m_next;
    logic [15:0]  frac_reg, frac_next;
    logic [NW-1:0] n_reg, n_next;
    logic [DW-1:0] d_reg, d_next;
    logic [LevelW-1:0] level_reg, level_next;
    logic         interior_reg, interior_next;
    logic [17:0]  rem_reg, rem_next;
    logic [15:0]  root_reg, root_next;
    logic [31:0]  sqv_reg, sqv_next;
    logic         done_reg, done_next;
    logic [ColorW-1:0] red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [LevelW-1:0] plev_reg, plev_next;

    // shared multiplier and its operand selection
    logic [63:0]  zr_mag, zi_mag, mul_a, mul_b;
    logic [31:0]  mul_x, mul_y;
    logic [63:0]  mult_out;
    logic [1:0]   part_k;
    logic [127:0] part_sh;
    logic         mul_last;

    // iteration update
    logic [63:0]  upd_pm;
    logic signed [63:0] upd_nr, upd_ni;
    logic         esc;

    // log2 unit
    logic         norm_hit;
    logic [127:0] norm_sh;
    logic [6:0]   norm_amt;
    logic [31:0]  log_sq;
    logic [15:0]  frac_new;
    logic [30:0]  m_new;
    logic [6:0]   log_p;
    logic [22:0]  log_val, log_t;
    logic [NW:0]  nplus;
    logic [DW-1:0] diff, d_abs;

    // level, square root and grey
    logic [63:0]  lvl_rnd;
    logic [LevelW-1:0] lvl_sat;
    logic [19:0]  sq_rem_sh, sq_trial;
    logic         sq_take;
    logic [35:0]  g_lin;
    logic [23:0]  g_frac;
    logic [16:0]  g_w;
    logic [24:0]  g_sqrt;
    logic [ColorW-1:0] grey;

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;
    assign potential_level = plev_reg;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= ResetGradientMode;
            bnd_level_reg   <= ResetBoundaryLevel;
            noise_level_reg <= ResetNoiseLevel;
            bnd_color_reg   <= ResetBoundaryColor;
            noise_color_reg <= ResetNoiseColor;
            int_color_reg   <= ResetInteriorColor;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegGradientMode:  mode_reg        <= cfg_data[1:0];
                RegBoundaryLevel: bnd_level_reg   <= cfg_data[LevelW-1:0];
                RegNoiseLevel:    noise_level_reg <= cfg_data[LevelW-1:0];
                RegBoundaryColor: bnd_color_reg   <= cfg_data[ColorW-1:0];
                RegNoiseColor:    noise_color_reg <= cfg_data[ColorW-1:0];
                RegInteriorColor: int_color_reg   <= cfg_data[ColorW-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- multiplier ----------------
    assign zr_mag = zr_reg[63] ? (64'd0 - zr_reg) : zr_reg;
    assign zi_mag = zi_reg[63] ? (64'd0 - zi_reg) : zi_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_MUL_ZRI: begin mul_a = zr_mag;         mul_b = zi_mag; end
            ST_MUL_SR:  begin mul_a = zr_mag;         mul_b = zr_mag; end
            ST_MUL_SI:  begin mul_a = zi_mag;         mul_b = zi_mag; end
            ST_MUL_LVL: begin mul_a = 64'(d_reg);     mul_b = Ln2Q24; end
            default:    begin mul_a = 64'd0;          mul_b = 64'd0;  end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_LOG)
        begin
            mul_x = {1'b0, m_reg};
            mul_y = {1'b0, m_reg};
        end
        else
        begin
            mul_x = step_reg[0] ? mul_a[63:32] : mul_a[31:0];
            mul_y = step_reg[1] ? mul_b[63:32] : mul_b[31:0];
        end
    end

    assign mult_out = {32'd0, mul_x} * {32'd0, mul_y};

    // partial k sits 32*(k0+k1) bits up
    assign part_k   = step_reg[1:0] - 2'd1;
    assign mul_last = (step_reg == 3'd4);

    always_comb
    begin
        unique case (part_k)
            2'd0:    part_sh = {64'd0, prod_reg};
            2'd1,
            2'd2:    part_sh = {32'd0, prod_reg, 32'd0};
            default: part_sh = {prod_reg, 64'd0};
        endcase
    end

    // ---------------- iteration ----------------
    assign upd_pm = {1'b0, acc_reg[89:27]};
    assign upd_ni = ((zr_reg[63] ^ zi_reg[63]) ? (64'd0 - upd_pm) : upd_pm)
                    + {{32{ci_reg[31]}}, ci_reg};
    assign upd_nr = {1'b0, sr_reg[90:28]} - {1'b0, si_reg[90:28]}
                    + {{32{cr_reg[31]}}, cr_reg};

    assign esc = (|norm_reg[127:92]) || (norm_reg[91:28] > EscLimit);

    // ---------------- log2 ----------------
    always_comb
    begin
        unique case (step_reg)
            3'd0: begin norm_hit = ~|norm_reg[127:64];
                        norm_sh  = {norm_reg[63:0], 64'd0};  norm_amt = 7'd64; end
            3'd1: begin norm_hit = ~|norm_reg[127:96];
                        norm_sh  = {norm_reg[95:0], 32'd0};  norm_amt = 7'd32; end
            3'd2: begin norm_hit = ~|norm_reg[127:112];
                        norm_sh  = {norm_reg[111:0], 16'd0}; norm_amt = 7'd16; end
            3'd3: begin norm_hit = ~|norm_reg[127:120];
                        norm_sh  = {norm_reg[119:0], 8'd0};  norm_amt = 7'd8;  end
            3'd4: begin norm_hit = ~|norm_reg[127:124];
                        norm_sh  = {norm_reg[123:0], 4'd0};  norm_amt = 7'd4;  end
            3'd5: begin norm_hit = ~|norm_reg[127:126];
                        norm_sh  = {norm_reg[125:0], 2'd0};  norm_amt = 7'd2;  end
            3'd6: begin norm_hit = ~norm_reg[127];
                        norm_sh  = {norm_reg[126:0], 1'b0};  norm_amt = 7'd1;  end
            default: begin norm_hit = 1'b0; norm_sh = norm_reg; norm_amt = 7'd0; end
        endcase
    end

    assign log_sq   = prod_reg[61:30];
    assign m_new    = log_sq[31] ? log_sq[31:1] : log_sq[30:0];
    assign frac_new = {frac_reg[14:0], log_sq[31]};
    assign log_p    = 7'd127 - shcnt_reg;
    assign log_val  = {log_p, frac_new};
    assign log_t    = log_val - 23'(56 << 16);

    assign nplus = (NW + 1)'(n_reg) + (NW + 1)'(18);
    assign diff  = DW'(log_val) - DW'({nplus, 16'd0});
    assign d_abs = diff[DW-1] ? (DW'(0) - diff) : diff;

    // ---------------- level and shade ----------------
    assign lvl_rnd = acc_reg[63:0] + 64'd8388608;
    assign lvl_sat = (|lvl_rnd[63:52]) ? LevelMax : lvl_rnd[51:24];

    assign sq_rem_sh = {rem_reg, sqv_reg[31:30]};
    assign sq_trial  = {2'd0, root_reg, 2'b01};
    assign sq_take   = (sq_rem_sh >= sq_trial);

    assign g_lin  = {level_reg, 8'd0} - {8'd0, level_reg};
    assign g_frac = {level_reg[15:0], 8'd0} - {8'd0, level_reg[15:0]};
    assign g_w    = 17'd65536 - {1'b0, root_reg};
    assign g_sqrt = {g_w, 8'd0} - {8'd0, g_w};

    always_comb
    begin
        priority if (level_reg > bnd_level_reg)
            grey = bnd_color_reg;
        else if (level_reg > noise_level_reg)
            grey = noise_color_reg;
        else if (mode_reg == GradLinear)
            grey = (|g_lin[35:24]) ? 8'd255 : g_lin[23:16];
        else if (mode_reg == GradFrac)
            grey = g_frac[23:16];
        else
            grey = g_sqrt[23:16];
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (start) state_next = ST_MUL_ZRI;
            ST_MUL_ZRI: if (mul_last) state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_MUL_SR;
            ST_MUL_SR:  if (mul_last) state_next = ST_MUL_SI;
            ST_MUL_SI:  if (mul_last) state_next = ST_SUM;
            ST_SUM:     state_next = ST_CHECK;
            ST_CHECK:
            begin
                priority if (esc)
                    state_next = ST_NORM;
                else if (n_reg == NW'(MAX_ITER))
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL_ZRI;
            end
            ST_NORM:    if (step_reg == 3'd6) state_next = ST_LOG;
            ST_LOG:
            begin
                if (phase_reg && round_reg == 4'd15)
                    state_next = pass_reg ? ST_MUL_LVL : ST_NORM;
            end
            ST_MUL_LVL: if (mul_last) state_next = ST_LEVEL;
            ST_LEVEL:   state_next = ST_SQRT;
            ST_SQRT:    if (round_reg == 4'd15) state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: datapath ----------------
    always_comb
    begin
        step_next     = step_reg;
        round_next    = round_reg;
        phase_next    = phase_reg;
        pass_next     = pass_reg;
        cr_next       = cr_reg;
        ci_next       = ci_reg;
        zr_next       = zr_reg;
        zi_next       = zi_reg;
        sr_next       = sr_reg;
        si_next       = si_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        norm_next     = norm_reg;
        shcnt_next    = shcnt_reg;
        m_next        = m_reg;
        frac_next     = frac_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        level_next    = level_reg;
        interior_next = interior_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        sqv_next      = sqv_reg;
        done_next     = 1'b0;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        plev_next     = plev_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cr_next       = c_re;
                    ci_next       = c_im;
                    zr_next       = 64'sd0;
                    zi_next       = 64'sd0;
                    sr_next       = 128'd0;
                    si_next       = 128'd0;
                    n_next        = NW'(1);
                    step_next     = 3'd0;
                    interior_next = 1'b0;
                end
            end
            ST_MUL_ZRI, ST_MUL_SR, ST_MUL_SI, ST_MUL_LVL:
            begin
                // a product of a fresh square is picked up by the next multiply
                if (state_reg == ST_MUL_SI && step_reg == 3'd0)
                    sr_next = acc_reg;
                if (!mul_last)
                    prod_next = mult_out;
                if (step_reg != 3'd0)
                    acc_next = (step_reg == 3'd1) ? part_sh : (acc_reg + part_sh);
                step_next = mul_last ? 3'd0 : (step_reg + 3'd1);
            end
            ST_UPDATE:
            begin
                zr_next = upd_nr;
                zi_next = upd_ni;
            end
            ST_SUM:
            begin
                si_next   = acc_reg;
                norm_next = sr_reg + acc_reg;
            end
            ST_CHECK:
            begin
                priority if (esc)
                begin
                    step_next  = 3'd0;
                    shcnt_next = 7'd0;
                    pass_next  = 1'b0;
                end
                else if (n_reg == NW'(MAX_ITER))
                    interior_next = 1'b1;
                else
                    n_next = n_reg + NW'(1);
            end
            ST_NORM:
            begin
                if (norm_hit)
                begin
                    norm_next  = norm_sh;
                    shcnt_next = shcnt_reg + norm_amt;
                end
                if (step_reg == 3'd6)
                begin
                    m_next     = norm_hit ? norm_sh[127:97] : norm_reg[127:97];
                    round_next = 4'd0;
                    phase_next = 1'b0;
                    step_next  = 3'd0;
                end
                else
                    step_next = step_reg + 3'd1;
            end
            ST_LOG:
            begin
                if (!phase_reg)
                begin
                    prod_next  = mult_out;
                    phase_next = 1'b1;
                end
                else
                begin
                    m_next     = m_new;
                    frac_next  = frac_new;
                    phase_next = 1'b0;
                    round_next = round_reg + 4'd1;
                    if (round_reg == 4'd15)
                    begin
                        if (!pass_reg)
                        begin
                            // second pass: log2 of log2|z|^2
                            norm_next  = 128'(log_t);
                            shcnt_next = 7'd0;
                            step_next  = 3'd0;
                            pass_next  = 1'b1;
                        end
                        else
                        begin
                            d_next    = d_abs;
                            step_next = 3'd0;
                        end
                    end
                end
            end
            ST_LEVEL:
            begin
                level_next = lvl_sat;
                sqv_next   = {lvl_sat[15:0], 16'd0};
                rem_next   = 18'd0;
                root_next  = 16'd0;
                round_next = 4'd0;
            end
            ST_SQRT:
            begin
                // restoring square root, one result bit per cycle
                if (sq_take)
                begin
                    rem_next  = 18'(sq_rem_sh - sq_trial);
                    root_next = {root_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_rem_sh[17:0];
                    root_next = {root_reg[14:0], 1'b0};
                end
                sqv_next   = {sqv_reg[29:0], 2'd0};
                round_next = round_reg + 4'd1;
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
                if (interior_reg)
                begin
                    red_next   = 8'd0;
                    green_next = 8'd0;
                    blue_next  = int_color_reg;
                    plev_next  = '0;
                end
                else
                begin
                    red_next   = grey;
                    green_next = grey;
                    blue_next  = grey;
                    plev_next  = level_reg;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
            round_reg <= 4'd0;
            phase_reg <= 1'b0;
            pass_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            phase_reg <= phase_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        zr_reg       <= zr_next;
        zi_reg       <= zi_next;
        sr_reg       <= sr_next;
        si_reg       <= si_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        norm_reg     <= norm_next;
        shcnt_reg    <= shcnt_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        level_reg    <= level_next;
        interior_reg <= interior_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        sqv_reg      <= sqv_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        plev_reg     <= plev_next;
    end

endmodule

`default_nettype wire

FILE: src/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker: port-level checks of the mandelbrot potential shader
// request and result strobe ordering, bound onto the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mps_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [mps_pkg::ColorW-1:0]    red,
    input wire logic [mps_pkg::ColorW-1:0]    green
);

    import mps_pkg::*;

    // a taken request keeps the block busy
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // every request ends in a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("block went idle without a result");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red == green))
        else $error("red and green differ");

endmodule

bind mandelbrot_potential_shader mps_checker u_mps_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .red   (red),
    .green (green)
);

`default_nettype wire

FILE: sim/tb_mandelbrot_potential_shader.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_potential_shader: self-checking bench for the potential shader
// drives points through the start/busy port and predicts every pixel from a
// bit-exact fixed-point model, over several register settings and random idling
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mandelbrot_potential_shader;
    import mps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // small iteration limit keeps interior points cheap
    localparam int IterLimit = 128;
    localparam int WatchLimit = 20000;
    localparam logic [1:0] GradSqrt  = 2'd2;
    localparam logic [1:0] GradSpare = 2'd3;

    typedef struct {
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
        logic [LevelW-1:0] level;
    } pixel_t;

    class pixel_scoreboard;
        logic [1:0]        grad_mode;
        logic [LevelW-1:0] bound_lvl;
        logic [LevelW-1:0] noise_lvl;
        logic [ColorW-1:0] bound_col;
        logic [ColorW-1:0] noise_col;
        logic [ColorW-1:0] inner_col;
        pixel_t            pending[$];
        int                errors;

        function new();
            grad_mode = ResetGradientMode;
            bound_lvl = ResetBoundaryLevel;
            noise_lvl = ResetNoiseLevel;
            bound_col = ResetBoundaryColor;
            noise_col = ResetNoiseColor;
            inner_col = ResetInteriorColor;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                RegGradientMode:  grad_mode = val[1:0];
                RegBoundaryLevel: bound_lvl = val;
                RegNoiseLevel:    noise_lvl = val;
                RegBoundaryColor: bound_col = val[7:0];
                RegNoiseColor:    noise_col = val[7:0];
                RegInteriorColor: inner_col = val[7:0];
                default: ;
            endcase
        endfunction

        static function logic [63:0] magnitude(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // product magnitude shifted right with truncation, sign put back
        static function longint mul_trunc(longint a, longint b, int sh);
            logic [127:0] p;
            logic [63:0]  r;
            p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
            r = 64'(p >> sh);
            r[63] = 1'b0;
            return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
        endfunction

        // floor log2 in Q.16 by repeated squaring of a 31-bit mantissa
        static function logic [63:0] log2_fixed(logic [127:0] v);
            int          p;
            logic [63:0] m;
            logic [63:0] f;
            p = 0;
            for (int k = 0; k < 128; k++)
                if (v[k]) p = k;
            if (p >= 30) m = 64'(v >> (p - 30));
            else         m = 64'(v << (30 - p));
            m = m & 64'h7FFF_FFFF;
            f = 0;
            for (int k = 0; k < 16; k++)
            begin
                m = (m * m) >> 30;
                f = f << 1;
                if (m >= 64'h8000_0000)
                begin
                    m = m >> 1;
                    f = f | 1;
                end
            end
            return (64'(p) << 16) | f;
        endfunction

        static function logic [31:0] sqrt_floor(logic [31:0] v);
            logic [31:0] r;
            logic [31:0] b;
            r = 0;
            b = 32'h4000_0000;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function pixel_t shade(logic signed [31:0] c_r, logic signed [31:0] c_i);
            longint       zr, zi, nr, ni, diff;
            logic [127:0] sum;
            logic [63:0]  t, d, lvl, grey, s;
            int           n;
            bit           escaped;
            pixel_t       px;
            zr = 0;
            zi = 0;
            escaped = 0;
            sum = 0;
            for (n = 1; n <= IterLimit; n++)
            begin
                nr = mul_trunc(zr, zr, 28) - mul_trunc(zi, zi, 28) + longint'(c_r);
                ni = mul_trunc(zr, zi, 27) + longint'(c_i);
                zr = nr;
                zi = ni;
                sum = {64'b0, magnitude(zr)} * {64'b0, magnitude(zr)}
                    + {64'b0, magnitude(zi)} * {64'b0, magnitude(zi)};
                if (sum[127:92] != 0 || sum[91:28] > EscLimit)
                begin
                    escaped = 1;
                    break;
                end
            end
            if (!escaped)
            begin
                px.red = 0;
                px.green = 0;
                px.blue = inner_col;
                px.level = 0;
                return px;
            end
            t = log2_fixed(sum) - (64'd56 << 16);
            diff = longint'(log2_fixed({64'b0, t})) - longint'(64'(n + 18) << 16);
            d = magnitude(diff);
            lvl = (d * Ln2Q24 + (64'd1 << 23)) >> 24;
            if (lvl > 64'(LevelMax)) lvl = 64'(LevelMax);
            if (lvl > 64'(bound_lvl))      grey = 64'(bound_col);
            else if (lvl > 64'(noise_lvl)) grey = 64'(noise_col);
            else if (grad_mode == GradLinear)
            begin
                grey = (255 * lvl) >> 16;
                if (grey > 255) grey = 255;
            end
            else if (grad_mode == GradFrac) grey = (255 * (lvl & 64'hFFFF)) >> 16;
            else
            begin
                s = 64'(sqrt_floor(32'((lvl & 64'hFFFF) << 16)));
                grey = (255 * (65536 - s)) >> 16;
            end
            px.red = grey[7:0];
            px.green = grey[7:0];
            px.blue = grey[7:0];
            px.level = lvl[LevelW-1:0];
            return px;
        endfunction

        function void note_request(logic signed [31:0] c_r, logic signed [31:0] c_i);
            pending.push_back(shade(c_r, c_i));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (pending.size() == 0)
            begin
                report("unexpected pixel", 64'(got.level), 0);
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red)     report("red", 64'(got.red), 64'(want.red));
            if (got.green !== want.green) report("green", 64'(got.green), 64'(want.green));
            if (got.blue !== want.blue)   report("blue", 64'(got.blue), 64'(want.blue));
            if (got.level !== want.level) report("level", 64'(got.level), 64'(want.level));
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [CoordW-1:0]   c_re;
    logic signed [CoordW-1:0]   c_im;
    logic                       done;
    logic [ColorW-1:0]          red;
    logic [ColorW-1:0]          green;
    logic [ColorW-1:0]          blue;
    logic [LevelW-1:0]          potential_level;
    logic                       cfg_we;
    logic [CfgIndexW-1:0]       cfg_index;
    logic [CfgDataW-1:0]        cfg_data;

    pixel_scoreboard sb = new();
    int              quiet_cycles;
    bit              calm;

    mandelbrot_potential_shader #(
        .MAX_ITER (IterLimit)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .c_re            (c_re),
        .c_im            (c_im),
        .done            (done),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .potential_level (potential_level),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pixel_t px;
        if (done)
        begin
            px.red = red;
            px.green = green;
            px.blue = blue;
            px.level = potential_level;
            sb.check_pixel(px);
        end
    end

    // watchdog: cycles with neither an accepted request nor a pixel
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_point(logic signed [31:0] c_r, logic signed [31:0] c_i);
        int gap;
        start <= 1'b1;
        c_re <= c_r;
        c_im <= c_i;
        do @(posedge clk); while (busy);
        sb.note_request(c_r, c_i);
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic signed [31:0] c_r, c_i;
        if ($urandom_range(0, 4) == 0)
        begin
            c_r = $urandom;
            c_i = $urandom;
        end
        else
        begin
            // most points near the set, where iteration counts vary widely
            c_r = $signed($urandom_range(0, 1073741824)) - 671088640;
            c_i = $signed($urandom_range(0, 805306368)) - 402653184;
        end
        send_point(c_r, c_i);
    endtask

    task automatic idle_start();
        @(posedge clk);
        start <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        c_re = '0;
        c_im = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: origin, the spike tip, extremes of both fields, near edge
        send_point(32'sd0, 32'sd0);
        send_point(-32'sd536870912, 32'sd0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sd0);
        send_point(32'sd0, 32'sd268435456);
        send_point(32'sd69793218, 32'sd0);
        send_point(32'sd80530636, 32'sd0);
        send_point(-32'sd201326592, 32'sd201326592);
        send_point(32'sd107374182, 32'sd161061273);
        send_point(-32'sd1, 32'sd1);
        send_point(32'sd134217728, 32'sd268435456);
        idle_start();
        wait_drained();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: write_reg(RegGradientMode, GradLinear);
                1:
                begin
                    write_reg(RegGradientMode, GradFrac);
                    write_reg(RegBoundaryLevel, LevelMax);
                    write_reg(RegNoiseLevel, LevelMax);
                end
                2:
                begin
                    write_reg(RegGradientMode, GradSqrt);
                    write_reg(RegNoiseLevel, 28'd65536);
                    write_reg(RegNoiseColor, 8'd0);
                    write_reg(RegInteriorColor, 8'd255);
                end
                3:
                begin
                    write_reg(RegGradientMode, GradSpare);
                    write_reg(RegBoundaryLevel, 28'd0);
                    write_reg(RegBoundaryColor, 8'd0);
                    write_reg(RegInteriorColor, 8'd0);
                end
                4:
                begin
                    write_reg(RegGradientMode, GradLinear);
                    write_reg(RegBoundaryLevel, $urandom_range(0, 500000));
                    write_reg(RegNoiseLevel, $urandom_range(0, 400000));
                    write_reg(RegBoundaryColor, $urandom_range(0, 255));
                    write_reg(RegNoiseColor, 8'd255);
                end
                5:
                begin
                    write_reg(RegGradientMode, GradFrac);
                    write_reg(RegNoiseLevel, 28'd0);
                    write_reg(RegBoundaryLevel, LevelMax);
                end
                default:
                begin
                    write_reg(RegGradientMode, GradSqrt);
                    write_reg(RegBoundaryLevel, ResetBoundaryLevel);
                    write_reg(RegNoiseLevel, ResetNoiseLevel);
                    calm = 1;
                end
            endcase
            for (int k = 0; k < 21; k++)
            begin
                send_random();
                // let the block drain once with no request pending
                if (phase == 2 && k == 10)
                begin
                    idle_start();
                    wait_drained();
                end
            end
            idle_start();
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: mandelbrot_potential_shader.f
src/mps_pkg.sv
src/mandelbrot_potential_shader.sv
src/mps_checker.sv
sim/tb_mandelbrot_potential_shader.sv
